@@ rtl/core/mhpq_pkg.sv @@
// ============================================================================
// mhpq_pkg
// Shared types and constants for the min-heap priority queue.
// ============================================================================
package mhpq_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int KEY_W  = 32;
    localparam int VAL_W  = 32;

    typedef enum logic [2:0] {
        FN_INSERT  = 3'd0,
        FN_EXTRACT = 3'd1,
        FN_REMOVE  = 3'd2,
        FN_SEARCH  = 3'd3,
        FN_CLEAR   = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_EMPTY    = 2'd2,
        STAT_NOTFOUND = 2'd3
    } t_status;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } t_entry;

    // first field in the highest bits
    typedef struct packed {
        logic signed [VAL_W-1:0] payload;
        logic signed [KEY_W-1:0] key;
        logic [2:0]              func;
    } t_req;

    typedef struct packed {
        logic [CNT_W-1:0]        count;
        logic signed [VAL_W-1:0] value;
        t_status                 status;
    } t_result;

    localparam int ENTRY_W = $bits(t_entry);
    localparam int REQ_W   = $bits(t_req);
    localparam int RES_W   = $bits(t_result);
    localparam int S_TDATA_W = ((REQ_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;

endpackage

@@ rtl/core/mhpq_ram.sv @@
// ============================================================================
// mhpq_ram
// Simple dual-read RAM: one write port, two registered read ports.
// ============================================================================
module mhpq_ram #(
    parameter int DATA_W = 64,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_rea,
    input  logic [ADDR_W-1:0] i_raddr_a,
    output logic [DATA_W-1:0] o_rdata_a,
    input  logic              i_reb,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output logic [DATA_W-1:0] o_rdata_b
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rea) begin
            o_rdata_a <= r_mem[i_raddr_a];
        end
        if (i_reb) begin
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

@@ rtl/core/mhpq_cmp.sv @@
// ============================================================================
// mhpq_cmp
// Shared key comparator: signed less-than and equality.
// ============================================================================
module mhpq_cmp (
    input  logic signed [mhpq_pkg::KEY_W-1:0] i_a,
    input  logic signed [mhpq_pkg::KEY_W-1:0] i_b,
    output logic                              o_lt,
    output logic                              o_eq
);

    import mhpq_pkg::*;

    assign o_lt = (i_a < i_b);
    assign o_eq = (i_a == i_b);

endmodule

@@ rtl/core/mhpq_ctrl.sv @@
// ============================================================================
// mhpq_ctrl
// Heap sequencer: sift-up, sift-down and linear key scan over the heap RAM.
// ============================================================================
module mhpq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  mhpq_pkg::t_req    i_req,
    output logic              o_res_valid,
    input  logic              i_res_take,
    output mhpq_pkg::t_result o_res
);

    import mhpq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_SC_RD,
        S_SC_CMP,
        S_RS_RD,
        S_RS_WR,
        S_EX_RD,
        S_EX_LD,
        S_DN_RD,
        S_DN_C1,
        S_DN_C2,
        S_RESP
    } t_state;

    t_state                  r_state, n_state;
    t_func                   r_func, n_func;
    logic signed [KEY_W-1:0] r_key, n_key;
    t_entry                  r_cur, n_cur;
    t_entry                  r_pick, n_pick;
    logic [CNT_W-1:0]        r_pick_idx, n_pick_idx;
    logic [CNT_W-1:0]        r_idx, n_idx;
    logic [CNT_W-1:0]        r_count, n_count;
    t_status                 r_status, n_status;
    logic signed [VAL_W-1:0] r_value, n_value;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    t_entry            ram_wdata;
    logic              ram_rea;
    logic [ADDR_W-1:0] ram_raddr_a;
    logic              ram_reb;
    logic [ADDR_W-1:0] ram_raddr_b;
    logic [ENTRY_W-1:0] ram_rdata_a;
    logic [ENTRY_W-1:0] ram_rdata_b;
    t_entry            rd_a;
    t_entry            rd_b;

    logic signed [KEY_W-1:0] cmp_a;
    logic signed [KEY_W-1:0] cmp_b;
    logic                    cmp_lt;
    logic                    cmp_eq;

    logic [CNT_W-1:0] par;
    logic [CNT_W:0]   lch;
    logic [CNT_W+1:0] rch;
    logic [CNT_W-1:0] last;

    mhpq_ram #(
        .DATA_W (ENTRY_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_rea     (ram_rea),
        .i_raddr_a (ram_raddr_a),
        .o_rdata_a (ram_rdata_a),
        .i_reb     (ram_reb),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_b (ram_rdata_b)
    );

    mhpq_cmp u_cmp (
        .i_a  (cmp_a),
        .i_b  (cmp_b),
        .o_lt (cmp_lt),
        .o_eq (cmp_eq)
    );

    assign rd_a = t_entry'(ram_rdata_a);
    assign rd_b = t_entry'(ram_rdata_b);

    assign par  = (r_idx - CNT_W'(1)) >> 1;
    assign lch  = {r_idx, 1'b1};
    assign rch  = {1'b0, lch} + (CNT_W+2)'(1);
    assign last = r_count - CNT_W'(1);

    // comparator operand select
    always_comb begin
        case (r_state)
            S_UP_CMP: begin
                cmp_a = r_cur.key;
                cmp_b = rd_a.key;
            end
            S_DN_C1: begin
                cmp_a = rd_a.key;
                cmp_b = r_cur.key;
            end
            S_DN_C2: begin
                cmp_a = rd_b.key;
                cmp_b = r_pick.key;
            end
            default: begin
                cmp_a = rd_a.key;
                cmp_b = r_key;
            end
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_func     = r_func;
        n_key      = r_key;
        n_cur      = r_cur;
        n_pick     = r_pick;
        n_pick_idx = r_pick_idx;
        n_idx      = r_idx;
        n_count    = r_count;
        n_status   = r_status;
        n_value    = r_value;

        ram_we      = 1'b0;
        ram_waddr   = r_idx[ADDR_W-1:0];
        ram_wdata   = r_cur;
        ram_rea     = 1'b0;
        ram_raddr_a = par[ADDR_W-1:0];
        ram_reb     = 1'b0;
        ram_raddr_b = last[ADDR_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_func   = t_func'(i_req.func);
                    n_key    = i_req.key;
                    n_cur    = '{key: i_req.key, value: i_req.payload};
                    n_status = STAT_OK;
                    n_value  = '0;
                    n_idx    = '0;
                    case (t_func'(i_req.func))
                        FN_INSERT: begin
                            if (r_count == CNT_W'(DEPTH)) begin
                                n_status = STAT_FULL;
                                n_state  = S_RESP;
                            end else begin
                                n_idx   = r_count;
                                n_count = r_count + CNT_W'(1);
                                n_state = S_UP_RD;
                            end
                        end
                        FN_EXTRACT: begin
                            if (r_count == '0) begin
                                n_status = STAT_EMPTY;
                                n_state  = S_RESP;
                            end else begin
                                n_state = S_EX_RD;
                            end
                        end
                        FN_REMOVE, FN_SEARCH: begin
                            n_state = S_SC_RD;
                        end
                        FN_CLEAR: begin
                            n_count = '0;
                            n_state = S_RESP;
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end

            // sift-up with a hole at r_idx
            S_UP_RD: begin
                if (r_idx == '0) begin
                    ram_we  = 1'b1;
                    n_state = S_RESP;
                end else begin
                    ram_rea    = 1'b1;
                    n_pick_idx = par;
                    n_state    = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                ram_we = 1'b1;
                if (cmp_lt) begin
                    ram_wdata = rd_a;
                    n_idx     = r_pick_idx;
                    n_state   = S_UP_RD;
                end else begin
                    n_state = S_RESP;
                end
            end

            // linear key scan
            S_SC_RD: begin
                if (r_idx >= r_count) begin
                    n_status = STAT_NOTFOUND;
                    n_state  = S_RESP;
                end else begin
                    ram_rea     = 1'b1;
                    ram_raddr_a = r_idx[ADDR_W-1:0];
                    n_state     = S_SC_CMP;
                end
            end
            S_SC_CMP: begin
                if (cmp_eq) begin
                    n_value = rd_a.value;
                    n_state = (r_func == FN_SEARCH) ? S_RESP : S_RS_RD;
                end else begin
                    n_idx   = r_idx + CNT_W'(1);
                    n_state = S_SC_RD;
                end
            end

            // forced raise: shift ancestors down one level
            S_RS_RD: begin
                if (r_idx == '0) begin
                    n_state = S_EX_RD;
                end else begin
                    ram_rea    = 1'b1;
                    n_pick_idx = par;
                    n_state    = S_RS_WR;
                end
            end
            S_RS_WR: begin
                ram_we    = 1'b1;
                ram_wdata = rd_a;
                n_idx     = r_pick_idx;
                n_state   = S_RS_RD;
            end

            // take the root, last entry moves up
            S_EX_RD: begin
                ram_rea     = 1'b1;
                ram_raddr_a = '0;
                ram_reb     = 1'b1;
                ram_raddr_b = last[ADDR_W-1:0];
                n_state     = S_EX_LD;
            end
            S_EX_LD: begin
                if (r_func == FN_EXTRACT) begin
                    n_value = rd_a.value;
                end
                n_cur   = rd_b;
                n_count = last;
                n_idx   = '0;
                n_state = S_DN_RD;
            end

            // sift-down with a hole at r_idx
            S_DN_RD: begin
                if (lch >= {1'b0, r_count}) begin
                    ram_we  = 1'b1;
                    n_state = S_RESP;
                end else begin
                    ram_rea     = 1'b1;
                    ram_raddr_a = lch[ADDR_W-1:0];
                    ram_reb     = 1'b1;
                    ram_raddr_b = rch[ADDR_W-1:0];
                    n_state     = S_DN_C1;
                end
            end
            S_DN_C1: begin
                if (cmp_lt) begin
                    n_pick     = rd_a;
                    n_pick_idx = lch[CNT_W-1:0];
                end else begin
                    n_pick     = r_cur;
                    n_pick_idx = r_idx;
                end
                n_state = S_DN_C2;
            end
            S_DN_C2: begin
                ram_we = 1'b1;
                if ((rch < {2'b00, r_count}) && cmp_lt) begin
                    ram_wdata = rd_b;
                    n_idx     = rch[CNT_W-1:0];
                    n_state   = S_DN_RD;
                end else if (r_pick_idx == r_idx) begin
                    n_state = S_RESP;
                end else begin
                    ram_wdata = r_pick;
                    n_idx     = r_pick_idx;
                    n_state   = S_DN_RD;
                end
            end

            S_RESP: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_func     <= n_func;
        r_key      <= n_key;
        r_cur      <= n_cur;
        r_pick     <= n_pick;
        r_pick_idx <= n_pick_idx;
        r_idx      <= n_idx;
        r_status   <= n_status;
        r_value    <= n_value;
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_RESP);
    assign o_res       = '{count: r_count, value: r_value, status: r_status};

endmodule

@@ rtl/core/min_heap_priority_queue.sv @@
// ============================================================================
// min_heap_priority_queue
// Binary min-heap of signed key/value pairs with insert, extract-min,
// remove-by-key, search and clear; one result word per request word.
// ============================================================================
// Requests are taken one at a time; a request word is accepted only while the
// sequencer is idle, and a finished result waits in the output register while
// the next request is taken. Heap entries live in one RAM with one write port
// and two registered read ports. Insert climbs one level at a time, extract
// sinks one level at a time, search scans entry by entry, and remove scans,
// then shifts the ancestors down to the root, then runs an extract. Clear, a
// full insert, an empty extract and unused codes answer without touching the
// heap RAM. The RAM needs no clearing pass after reset; only entries below
// the count are ever used.
// ============================================================================
module min_heap_priority_queue (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // func[2:0], key[34:3], payload[66:35], zero pad
    input  logic [mhpq_pkg::S_TDATA_W-1:0]   i_s_tdata,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // status[1:0], result_value[33:2], entry_count[40:34], zero pad
    output logic [mhpq_pkg::M_TDATA_W-1:0]   o_m_tdata
);

    import mhpq_pkg::*;

    t_req    req;
    t_result res;
    logic    res_valid;
    logic    res_take;
    logic    r_out_valid;
    t_result r_out;

    assign req      = t_req'(i_s_tdata[REQ_W-1:0]);
    assign res_take = res_valid && (!r_out_valid || i_m_tready);

    mhpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_tvalid),
        .o_req_ready (o_s_tready),
        .i_req       (req),
        .o_res_valid (res_valid),
        .i_res_take  (res_take),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(M_TDATA_W - RES_W){1'b0}}, r_out};

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.count <= CNT_W'(DEPTH)))
        else $error("entry count above capacity");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.status != STAT_OK)) |-> (r_out.value == '0))
        else $error("nonzero value on refused request");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("request accepted while busy");
`endif

endmodule
